// ----- hdl/hs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sorter package
// Shared widths, item and record types, datapath operation codes and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package hs_pkg;

  // Store geometry: positions run 1..MAX_RECORDS, RAM addresses 0..MAX_RECORDS-1.
  localparam int MAX_RECORDS = 64;
  localparam int POS_W       = $clog2(MAX_RECORDS + 1);
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;
  localparam int REC_W       = KEY_W + PAY_W;

  // One input item.
  typedef struct packed {
    logic signed [KEY_W-1:0] in_key;
    logic signed [PAY_W-1:0] in_payload;
    logic                    in_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [KEY_W-1:0] out_key;
    logic signed [PAY_W-1:0] out_payload;
    logic                    out_last;
    logic                    out_overflow;
  } out_item_t;

  // One stored record.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [PAY_W-1:0] payload;
  } record_t;

  // Datapath operation codes.
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_B_INIT   = 5'd2;
  localparam logic [OP_W-1:0] OP_TOP_RD   = 5'd3;
  localparam logic [OP_W-1:0] OP_TOP_LD   = 5'd4;
  localparam logic [OP_W-1:0] OP_LCH      = 5'd5;
  localparam logic [OP_W-1:0] OP_RCH      = 5'd6;
  localparam logic [OP_W-1:0] OP_CMP      = 5'd7;
  localparam logic [OP_W-1:0] OP_PLACE    = 5'd8;
  localparam logic [OP_W-1:0] OP_DEC_I    = 5'd9;
  localparam logic [OP_W-1:0] OP_X_INIT   = 5'd10;
  localparam logic [OP_W-1:0] OP_SW_RD1   = 5'd11;
  localparam logic [OP_W-1:0] OP_SW_RDI   = 5'd12;
  localparam logic [OP_W-1:0] OP_SW_WR    = 5'd13;
  localparam logic [OP_W-1:0] OP_OUT_INIT = 5'd14;
  localparam logic [OP_W-1:0] OP_OUT_RD   = 5'd15;
  localparam logic [OP_W-1:0] OP_CLEAR    = 5'd16;

  // Command from controller to datapath.
  typedef struct packed {
    logic [OP_W-1:0] op;
  } hs_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic count_half_zero;   // fewer than two records stored
    logic top_has_child;     // sift start position has a left child in the heap
    logic child_lt_end;      // current left child has a right sibling
    logic chosen_has_child;  // chosen child position has a child in the heap
    logic move_lt_chosen;    // moving key is below the chosen child's key
    logic i_gt1;
    logic i_gt2;
    logic i_at_count;
  } hs_status_t;

  // Signed key compare: a < b.
  function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                    input logic signed [KEY_W-1:0] b);
    return a < b;
  endfunction

endpackage

// ----- hdl/hs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// ----- hdl/hs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sorter controller
// Sequences load, heap build, root extraction and output drain, and issues
// one datapath operation per cycle.
// ----------------------------------------------------------------------------
module hs_ctrl
  import hs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_last,
  input  hs_status_t status,
  output logic       busy,
  output hs_cmd_t    cmd
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] ST_B_INIT   = 4'd1;
  localparam logic [ST_W-1:0] ST_TOP_RD   = 4'd2;
  localparam logic [ST_W-1:0] ST_TOP_LD   = 4'd3;
  localparam logic [ST_W-1:0] ST_LCH      = 4'd4;
  localparam logic [ST_W-1:0] ST_RCH      = 4'd5;
  localparam logic [ST_W-1:0] ST_CMP      = 4'd6;
  localparam logic [ST_W-1:0] ST_PLACE    = 4'd7;
  localparam logic [ST_W-1:0] ST_SIFT_END = 4'd8;
  localparam logic [ST_W-1:0] ST_X_INIT   = 4'd9;
  localparam logic [ST_W-1:0] ST_SW_RD1   = 4'd10;
  localparam logic [ST_W-1:0] ST_SW_RDI   = 4'd11;
  localparam logic [ST_W-1:0] ST_SW_WR    = 4'd12;
  localparam logic [ST_W-1:0] ST_OUT_INIT = 4'd13;
  localparam logic [ST_W-1:0] ST_OUT_RD   = 4'd14;
  localparam logic [ST_W-1:0] ST_DONE     = 4'd15;

  logic [ST_W-1:0] state_r, state_nxt;
  logic            extract_r, extract_nxt;

  // State and phase registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      extract_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      extract_r <= extract_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  // Next state and datapath operation.
  always_comb begin
    state_nxt   = state_r;
    extract_nxt = extract_r;
    cmd.op      = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (in_last) begin
            state_nxt = ST_B_INIT;
          end
        end
      end
      ST_B_INIT: begin
        cmd.op      = OP_B_INIT;
        extract_nxt = 1'b0;
        state_nxt   = status.count_half_zero ? ST_OUT_INIT : ST_TOP_RD;
      end
      ST_TOP_RD: begin
        cmd.op    = OP_TOP_RD;
        state_nxt = ST_TOP_LD;
      end
      ST_TOP_LD: begin
        cmd.op    = OP_TOP_LD;
        state_nxt = status.top_has_child ? ST_LCH : ST_SIFT_END;
      end
      ST_LCH: begin
        cmd.op    = OP_LCH;
        state_nxt = status.child_lt_end ? ST_RCH : ST_CMP;
      end
      ST_RCH: begin
        cmd.op    = OP_RCH;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        cmd.op = OP_CMP;
        if (!status.move_lt_chosen) begin
          state_nxt = ST_SIFT_END;
        end else if (status.chosen_has_child) begin
          state_nxt = ST_LCH;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd.op    = OP_PLACE;
        state_nxt = ST_SIFT_END;
      end
      // One sift is finished: step to the next build position or tail.
      ST_SIFT_END: begin
        if (!extract_r) begin
          if (status.i_gt1) begin
            cmd.op    = OP_DEC_I;
            state_nxt = ST_TOP_RD;
          end else begin
            state_nxt = ST_X_INIT;
          end
        end else begin
          if (status.i_gt2) begin
            cmd.op    = OP_DEC_I;
            state_nxt = ST_SW_RD1;
          end else begin
            state_nxt = ST_OUT_INIT;
          end
        end
      end
      ST_X_INIT: begin
        cmd.op      = OP_X_INIT;
        extract_nxt = 1'b1;
        state_nxt   = ST_SW_RD1;
      end
      ST_SW_RD1: begin
        cmd.op    = OP_SW_RD1;
        state_nxt = ST_SW_RDI;
      end
      ST_SW_RDI: begin
        cmd.op    = OP_SW_RDI;
        state_nxt = ST_SW_WR;
      end
      ST_SW_WR: begin
        cmd.op    = OP_SW_WR;
        state_nxt = status.i_gt2 ? ST_LCH : ST_PLACE;
      end
      ST_OUT_INIT: begin
        cmd.op    = OP_OUT_INIT;
        state_nxt = ST_OUT_RD;
      end
      ST_OUT_RD: begin
        cmd.op    = OP_OUT_RD;
        state_nxt = status.i_at_count ? ST_DONE : ST_OUT_RD;
      end
      ST_DONE: begin
        cmd.op    = OP_CLEAR;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/hs_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sorter datapath
// Record store, sift registers, loop position counters and the result
// register, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module hs_dpath
  import hs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  hs_cmd_t    cmd,
  output hs_status_t status,
  output logic       out_valid,
  output out_item_t  out_data
);

  // Position (1-based) to RAM address.
  function automatic logic [ADDR_W-1:0] to_addr(input logic [POS_W:0] pos);
    logic [POS_W:0] tmp;
    tmp = pos - (POS_W + 1)'(1);
    return tmp[ADDR_W-1:0];
  endfunction

  logic [POS_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [POS_W-1:0] i_r, i_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [POS_W-1:0] hole_r, hole_nxt;
  logic [POS_W:0]   child_r, child_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt;
  record_t          moving_r, moving_nxt;
  record_t          left_r, left_nxt;
  record_t          chosen_r, chosen_nxt;
  record_t          temp_r, temp_nxt;
  logic             pend_r, pend_last_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  record_t           ram_wdata, ram_rdata;

  hs_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status toward the controller.
  always_comb begin
    status.count_half_zero  = ((count_r >> 1) == '0);
    status.top_has_child    = ({hole_r, 1'b0} <= {1'b0, end_r});
    status.child_lt_end     = (child_r < {1'b0, end_r});
    status.chosen_has_child = ({idx_r, 1'b0} <= {1'b0, end_r});
    status.move_lt_chosen   = key_less(moving_r.key, chosen_r.key);
    status.i_gt1            = (i_r > POS_W'(1));
    status.i_gt2            = (i_r > POS_W'(2));
    status.i_at_count       = (i_r == count_r);
  end

  // Operation decode: register updates and store accesses.
  always_comb begin
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    end_nxt    = end_r;
    hole_nxt   = hole_r;
    child_nxt  = child_r;
    idx_nxt    = idx_r;
    moving_nxt = moving_r;
    left_nxt   = left_r;
    chosen_nxt = chosen_r;
    temp_nxt   = temp_r;
    ram_we     = 1'b0;
    ram_waddr  = to_addr({1'b0, hole_r});
    ram_wdata  = moving_r;
    ram_raddr  = '0;
    unique case (cmd.op)
      OP_NONE: begin
      end
      // Append the item, or drop it when the store is full.
      OP_LOAD: begin
        if (count_r < POS_W'(MAX_RECORDS)) begin
          ram_we            = 1'b1;
          ram_waddr         = count_r[ADDR_W-1:0];
          ram_wdata.key     = in_data.in_key;
          ram_wdata.payload = in_data.in_payload;
          count_nxt         = count_r + POS_W'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      OP_B_INIT: begin
        i_nxt   = count_r >> 1;
        end_nxt = count_r;
      end
      OP_TOP_RD: begin
        ram_raddr = to_addr({1'b0, i_r});
        hole_nxt  = i_r;
      end
      OP_TOP_LD: begin
        moving_nxt = ram_rdata;
        child_nxt  = {hole_r, 1'b0};
        ram_raddr  = to_addr({hole_r, 1'b0});
      end
      // Left child arrives; fetch the right one when it exists.
      OP_LCH: begin
        if (child_r < {1'b0, end_r}) begin
          left_nxt  = ram_rdata;
          ram_raddr = child_r[ADDR_W-1:0];
        end else begin
          chosen_nxt = ram_rdata;
          idx_nxt    = child_r[POS_W-1:0];
        end
      end
      // Right child wins only when the left key is strictly smaller.
      OP_RCH: begin
        if (key_less(left_r.key, ram_rdata.key)) begin
          chosen_nxt = ram_rdata;
          idx_nxt    = child_r[POS_W-1:0] + POS_W'(1);
        end else begin
          chosen_nxt = left_r;
          idx_nxt    = child_r[POS_W-1:0];
        end
      end
      // Move the child up, or settle the moving record in the hole.
      OP_CMP: begin
        ram_we = 1'b1;
        if (key_less(moving_r.key, chosen_r.key)) begin
          ram_wdata = chosen_r;
          hole_nxt  = idx_r;
          child_nxt = {idx_r, 1'b0};
          ram_raddr = to_addr({idx_r, 1'b0});
        end
      end
      OP_PLACE: begin
        ram_we = 1'b1;
      end
      OP_DEC_I: begin
        i_nxt = i_r - POS_W'(1);
      end
      OP_X_INIT: begin
        i_nxt = count_r;
      end
      OP_SW_RD1: begin
        ram_raddr = to_addr((POS_W + 1)'(1));
      end
      OP_SW_RDI: begin
        ram_raddr = to_addr({1'b0, i_r});
        temp_nxt  = ram_rdata;
      end
      // Old root goes to the tail; the tail record sifts down from the root.
      OP_SW_WR: begin
        moving_nxt = ram_rdata;
        ram_we     = 1'b1;
        ram_waddr  = to_addr({1'b0, i_r});
        ram_wdata  = temp_r;
        hole_nxt   = POS_W'(1);
        end_nxt    = i_r - POS_W'(1);
        child_nxt  = (POS_W + 1)'(2);
        ram_raddr  = to_addr((POS_W + 1)'(2));
      end
      OP_OUT_INIT: begin
        i_nxt = POS_W'(1);
      end
      OP_OUT_RD: begin
        ram_raddr = to_addr({1'b0, i_r});
        i_nxt     = i_r + POS_W'(1);
      end
      OP_CLEAR: begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= (cmd.op == OP_OUT_RD);
      out_valid_r <= pend_r;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    end_r       <= end_nxt;
    hole_r      <= hole_nxt;
    child_r     <= child_nxt;
    idx_r       <= idx_nxt;
    moving_r    <= moving_nxt;
    left_r      <= left_nxt;
    chosen_r    <= chosen_nxt;
    temp_r      <= temp_nxt;
    pend_last_r <= (i_r == count_r);
  end

  // Result register, loaded in the cycle after each store read.
  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_data_r.out_key      <= ram_rdata.key;
      out_data_r.out_payload  <= ram_rdata.payload;
      out_data_r.out_last     <= pend_last_r;
      out_data_r.out_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/heap_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sorter
// Collects records of a signed key and a payload and sends them back in
// ascending key order after the record marked last, using a max-heap sort.
// ----------------------------------------------------------------------------
// Usage: present a record on in_data and raise start; it is taken at the
// rising edge where start is high and busy is low, so records can load one
// per cycle. Up to MAX_RECORDS records are kept; further records of the set
// are dropped and out_overflow is set on every result of that set.
// The record with in_last set ends the set: busy rises and the store is
// heap sorted in place through its single read port, then drained.
// Each heap level visited takes a left read, a right read when a right
// child exists, and a compare and write; each extraction swap reads the
// root, reads the tail record and writes the old root to the tail.
// Results follow on consecutive cycles, one per stored record, each marked
// by out_valid for exactly one cycle; out_last flags the final one. The
// first result follows the last sift step through the output setup, the
// store read and the result register; busy falls the cycle the final
// result is shown.
// The receiver cannot stall and must take each result when shown.
// Reset (rst_n low, synchronous) empties the set and clears overflow.
// ----------------------------------------------------------------------------
module heap_sorter
  import hs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  hs_cmd_t    cmd;
  hs_status_t status;

  hs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_data.in_last),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  hs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- hdl/hs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sorter checker
// Port-level assertions on the sort run and result burst, bound to the top.
// ----------------------------------------------------------------------------
module hs_checker
  import hs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // A sort run begins only after a last item is taken.
  a_busy_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_data.in_last))
    else $error("busy rose without a last item");

  // Results only come out of a sort run.
  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result item outside a sort run");

  // Results of one run are back to back.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_last) |=> out_valid)
    else $error("gap inside a result burst");

  // Nothing follows the final result directly.
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_last) |=> !out_valid)
    else $error("result item right after the final one");

  // The overflow flag is the same on every result of a run.
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.out_last) |=>
      (out_data.out_overflow == $past(out_data.out_overflow)))
    else $error("overflow flag changed within a run");

endmodule

bind heap_sorter hs_checker u_hs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ----- tb/sv/heap_sorter_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sorter testbench
// Feeds record sets into the sorter and checks every sorted result against a
// max-heap sort kept in the testbench. A short directed part covers extreme
// keys, single records and equal keys. Random sets follow, among them one
// that exactly fills the store and one that overflows it. Random gaps and
// back-to-back bursts sit between items.
// ----------------------------------------------------------------------------
module heap_sorter_test;
  import hs_pkg::*;

  localparam int RANDOM_ITEMS = 150;
  localparam int TAIL_CYCLES  = 60;

  // An item waiting for the driver, with the idle cycles that go before it.
  typedef struct {
    in_item_t    item;
    int unsigned gap;
  } pending_t;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_data;

  // Items still to drive and sorted results still to arrive.
  pending_t  item_queue[$];
  out_item_t sorted_expect[$];

  // The sorter's state as the testbench sees it.
  record_t   record_bank [1:MAX_RECORDS];
  int        held_count   = 0;
  logic      dropped_flag = 1'b0;

  // Run bookkeeping.
  int        total_items    = 0;
  int        accepted_count = 0;
  int        result_count   = 0;
  int        set_count      = 0;
  int        overflow_sets  = 0;
  int        error_count    = 0;
  int        set_length     = 0;
  longint    cycle_count    = 0;
  longint    cycle_limit    = 2000;
  logic      item_taken     = 1'b0;

  // Driver state.
  pending_t    current_item;
  logic        have_current = 1'b0;
  logic        presenting   = 1'b0;
  int unsigned gap_left     = 0;

  heap_sorter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Queue one item and extend the cycle limit when it closes a set.
  task automatic add_item(input logic [31:0] key, input logic [31:0] payload,
                          input logic last, input int unsigned gap);
    pending_t entry;
    int       stored;
    entry.item = '{in_key: key, in_payload: payload, in_last: last};
    entry.gap  = gap;
    item_queue.push_back(entry);
    total_items++;
    set_length++;
    if (last) begin
      // Budget the idle gap and loading of each record, the sort of the stored
      // records and a margin; allow four times that.
      stored      = (set_length < MAX_RECORDS) ? set_length : MAX_RECORDS;
      cycle_limit += 4 * (set_length * 11 + stored * 40 + 200);
      set_length  = 0;
      set_count++;
    end
  endtask

  // Sift the record at position top down through heap positions 1..heap_end.
  task automatic sift_record(input int top, input int heap_end);
    record_t moving;
    int      hole;
    int      child;
    logic    settled;
    moving  = record_bank[top];
    hole    = top;
    child   = 2 * hole;
    settled = 1'b0;
    while (!settled && child <= heap_end) begin
      // The right child wins only when the left key is strictly smaller.
      if (child < heap_end &&
          $signed(record_bank[child].key) < $signed(record_bank[child + 1].key)) begin
        child++;
      end
      if (!($signed(moving.key) < $signed(record_bank[child].key))) begin
        settled = 1'b1;
      end else begin
        record_bank[hole] = record_bank[child];
        hole  = child;
        child = 2 * hole;
      end
    end
    record_bank[hole] = moving;
  endtask

  // Store one accepted item; on the last one sort and queue the results.
  task automatic absorb_record(input in_item_t item);
    record_t swap;
    int      pos;
    if (held_count < MAX_RECORDS) begin
      held_count++;
      record_bank[held_count] = '{key: item.in_key, payload: item.in_payload};
    end else begin
      dropped_flag = 1'b1;
    end
    if (item.in_last) begin
      for (pos = held_count / 2; pos > 0; pos--) begin
        sift_record(pos, held_count);
      end
      for (pos = held_count; pos > 1; pos--) begin
        swap             = record_bank[1];
        record_bank[1]   = record_bank[pos];
        record_bank[pos] = swap;
        sift_record(1, pos - 1);
      end
      for (pos = 1; pos <= held_count; pos++) begin
        sorted_expect.push_back('{out_key:      record_bank[pos].key,
                                  out_payload:  record_bank[pos].payload,
                                  out_last:     (pos == held_count),
                                  out_overflow: dropped_flag});
      end
      if (dropped_flag) begin
        overflow_sets++;
      end
      held_count   = 0;
      dropped_flag = 1'b0;
    end
  endtask

  // Compare one result field and report a difference.
  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      $display("%0t ns: %s mismatch, expected 0x%08h, actual 0x%08h",
               $time, name, expected, actual);
      error_count++;
    end
  endtask

  // Driver: presents items at the falling edge and holds each until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (presenting && item_taken) begin
        presenting   = 1'b0;
        have_current = 1'b0;
      end
      if (!have_current && item_queue.size() > 0) begin
        current_item = item_queue.pop_front();
        have_current = 1'b1;
        gap_left     = current_item.gap;
      end
      if (have_current && !presenting) begin
        if (gap_left == 0) begin
          presenting = 1'b1;
        end else begin
          gap_left--;
        end
      end
      start <= presenting;
      if (presenting) begin
        in_data <= current_item.item;
      end
    end
  end

  // Monitor: records accepted items and checks each result at the rising edge.
  always @(posedge clk) begin
    out_item_t expected;
    if (rst_n && start && !busy) begin
      absorb_record(in_data);
      accepted_count++;
      item_taken <= 1'b1;
    end else begin
      item_taken <= 1'b0;
    end
    if (rst_n && out_valid) begin
      result_count++;
      if (sorted_expect.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual key 0x%08h",
                 $time, out_data.out_key);
        error_count++;
      end else begin
        expected = sorted_expect.pop_front();
        check_field("key", expected.out_key, out_data.out_key);
        check_field("payload", expected.out_payload, out_data.out_payload);
        check_field("last", 32'(expected.out_last), 32'(out_data.out_last));
        check_field("overflow", 32'(expected.out_overflow), 32'(out_data.out_overflow));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int          rand_items;
    int          rand_sets;
    int          size;
    int          idx;
    int          key_mode;
    logic        bursty;
    logic [31:0] key;
    int unsigned gap;

    // Directed: single records with extreme keys and payloads.
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 0);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 3);
    // Equal keys exercise the tie rules of the sift.
    add_item(32'd5, 32'd1, 1'b0, 0);
    add_item(32'd5, 32'd2, 1'b0, 0);
    add_item(32'd5, 32'd3, 1'b1, 0);
    // A descending pair.
    add_item(32'd7, 32'hFFFF_FFFF, 1'b0, 2);
    add_item(-32'sd7, 32'h0000_0000, 1'b1, 0);
    // Extreme and patterned keys with repeats.
    add_item(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 0);
    add_item(32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1);
    add_item(32'h0000_0000, 32'h5555_5555, 1'b0, 0);
    add_item(32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, 0);
    add_item(32'h0000_0001, 32'h0000_0001, 1'b0, 4);
    add_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 0);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 0);
    add_item(32'h5555_5555, 32'h1234_5678, 1'b0, 0);
    add_item(32'hAAAA_AAAA, 32'h8765_4321, 1'b0, 9);
    add_item(32'h0000_0000, 32'hDEAD_BEEF, 1'b1, 0);
    // Already ascending input.
    add_item(32'd1, 32'd10, 1'b0, 0);
    add_item(32'd2, 32'd20, 1'b0, 0);
    add_item(32'd3, 32'd30, 1'b0, 0);
    add_item(32'd4, 32'd40, 1'b1, 0);

    // Random sets: mostly small, one that fills the store exactly and one
    // that overflows it so that the record marked last is dropped.
    rand_items = 0;
    rand_sets  = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_sets == 2) begin
        size = MAX_RECORDS;
      end else if (rand_sets == 5) begin
        size = MAX_RECORDS + $urandom_range(1, 3);
      end else begin
        size = $urandom_range(1, 12);
      end
      key_mode = $urandom_range(0, 2);
      bursty   = ($urandom_range(0, 2) == 0);
      for (idx = 0; idx < size; idx++) begin
        case (key_mode)
          0: begin
            key = $urandom;
          end
          1: begin
            // Narrow range for many equal keys.
            key = 32'($urandom_range(0, 7)) - 32'd4;
          end
          default: begin
            case ($urandom_range(0, 4))
              0: key = 32'h7FFF_FFFF;
              1: key = 32'h8000_0000;
              2: key = 32'h0000_0000;
              3: key = 32'hFFFF_FFFF;
              default: key = $urandom;
            endcase
          end
        endcase
        gap = bursty ? 0 : $urandom_range(0, 9);
        add_item(key, $urandom, idx == size - 1, gap);
        rand_items++;
      end
      rand_sets++;
    end

    // Reset held low from the start, released at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for all items to be taken and all results to arrive.
    do begin
      @(posedge clk);
    end while (accepted_count != total_items || sorted_expect.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d record sets from %0d items, %0d of them over capacity.",
             set_count, total_items, overflow_sets);
    $display("Checked %0d sorted results, %0d errors.", result_count, error_count);
    if (error_count == 0 && sorted_expect.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
